[design/rv32i_execute_unit_top_assert.svh]
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top_assert
// Assertion macros for the RV32I execute unit.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_UNIT_TOP_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define RVX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define RVX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rvx_pkg.sv]
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants for the RV32I execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_ZERO   = 7'b0000000;
    localparam logic [6:0] FUNCT7_ALT = 7'b0100000;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    // Classified word passed from the front to the back
    typedef struct packed {
        logic        is_ret;
        logic [31:0] instr;
        logic [31:0] load_data;
        logic        illegal;
    } rvx_item_t;

endpackage

[design/rvx_front.sv]
// ----------------------------------------------------------------------------
// rvx_front
// Accepts input words, flags undefined encodings and queues them.
// ----------------------------------------------------------------------------
module rvx_front #(
    parameter int DEPTH = rvx_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [31:0]           instr,
    input  logic [31:0]           load_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output rvx_pkg::rvx_item_t    q_item
);
    import rvx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rvx_item_t          mem_reg [DEPTH];
    logic [AW-1:0]      wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]        cnt_reg, cnt_next;
    rvx_item_t          cls;
    logic               push, pop;
    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic               ill;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign f7  = instr[31:25];

    always_comb
    begin
        ill = 1'b0;
        unique case (opc) inside
            OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_FENCE, OPC_SYSTEM, OPC_ZERO: ill = 1'b0;
            OPC_JALR:   ill = (f3 != 3'd0);
            OPC_BRANCH: ill = (f3 == 3'd2) || (f3 == 3'd3);
            OPC_LOAD:   ill = (f3 == 3'd3) || (f3 >= 3'd6);
            OPC_STORE:  ill = (f3 >= 3'd3);
            OPC_OPIMM:
                if (f3 == 3'd1)
                    ill = (f7 != 7'd0);
                else if (f3 == 3'd5)
                    ill = (f7 != 7'd0) && (f7 != FUNCT7_ALT);
            OPC_OP:
                ill = !((f7 == 7'd0) ||
                        ((f7 == FUNCT7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5))));
            default:    ill = 1'b1;
        endcase
    end

    always_comb
    begin
        cls.is_ret    = op;
        cls.instr     = instr;
        cls.load_data = load_data;
        cls.illegal   = !op && ill;
    end

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ((wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = pop  ? ((rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= cls;
    end

endmodule

[design/rvx_back.sv]
// ----------------------------------------------------------------------------
// rvx_back
// Executes queued words against the register file and pc, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rvx_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  rvx_pkg::rvx_item_t    q_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           next_pc,
    output logic [1:0]            access_kind,
    output logic [31:0]           access_addr,
    output logic [2:0]            access_bytes,
    output logic [31:0]           store_data,
    output logic                  illegal,
    output logic                  console_valid,
    output logic [7:0]            console_char
);
    import rvx_pkg::*;

    logic [31:0] rf_reg [1:31];
    logic [31:0] pc_reg;
    logic        lp_reg, lp_next;
    logic [4:0]  ld_reg, ld_next;
    logic [2:0]  lk_reg, lk_next;
    logic        ov_reg;

    logic [31:0] w, a, b, immi, imms, immb, immj, r, npc, pc4, ext;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2, sh;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic        we, take, fire;
    logic [1:0]  kind;
    logic [31:0] addr, sdata;
    logic [2:0]  nb;
    logic        cv;
    logic [7:0]  cc;

    assign fire    = q_valid && q_ready;
    assign q_ready = !ov_reg || out_ready;

    assign w    = q_item.instr;
    assign opc  = w[6:0];
    assign rd   = w[11:7];
    assign f3   = w[14:12];
    assign rs1  = w[19:15];
    assign rs2  = w[24:20];
    assign f7   = w[31:25];
    assign a    = (rs1 == 5'd0) ? 32'd0 : rf_reg[rs1];
    assign b    = (rs2 == 5'd0) ? 32'd0 : rf_reg[rs2];
    assign immi = {{20{w[31]}}, w[31:20]};
    assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign pc4  = pc_reg + 32'd4;
    assign sh   = (opc == OPC_OP) ? b[4:0] : w[24:20];

    always_comb
    begin
        case (lk_reg)
            3'd0:    ext = {{24{q_item.load_data[7]}}, q_item.load_data[7:0]};
            3'd1:    ext = {{16{q_item.load_data[15]}}, q_item.load_data[15:0]};
            3'd4:    ext = {24'd0, q_item.load_data[7:0]};
            3'd5:    ext = {16'd0, q_item.load_data[15:0]};
            default: ext = q_item.load_data;
        endcase
    end

    // ALU shared by OP and OP-IMM
    always_comb
    begin
        logic [31:0] opb;
        opb = (opc == OPC_OP) ? b : immi;
        case (f3)
            3'd0:    r = ((opc == OPC_OP) && f7[5]) ? a - opb : a + opb;
            3'd1:    r = a << sh;
            3'd2:    r = {31'd0, $signed(a) < $signed(opb)};
            3'd3:    r = {31'd0, a < opb};
            3'd4:    r = a ^ opb;
            3'd5:    r = f7[5] ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6:    r = a | opb;
            default: r = a & opb;
        endcase
    end

    always_comb
    begin
        case (f3)
            3'd0:    take = (a == b);
            3'd1:    take = (a != b);
            3'd4:    take = $signed(a) < $signed(b);
            3'd5:    take = $signed(a) >= $signed(b);
            3'd6:    take = a < b;
            3'd7:    take = a >= b;
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        npc = pc4; kind = ACC_NONE; addr = '0; nb = '0; sdata = '0;
        cv = 1'b0; cc = '0; we = 1'b0;
        lp_next = lp_reg; ld_next = ld_reg; lk_next = lk_reg;
        if (q_item.is_ret)
        begin
            npc = pc_reg;
            we  = lp_reg;
            lp_next = 1'b0;
        end
        else
        begin
            lp_next = 1'b0;
            if (!q_item.illegal)
            begin
                unique case (opc) inside
                    OPC_LUI, OPC_AUIPC, OPC_OP, OPC_OPIMM: we = 1'b1;
                    OPC_JAL:
                    begin
                        we = 1'b1; npc = pc_reg + immj;
                    end
                    OPC_JALR:
                    begin
                        we = 1'b1; npc = (a + immi) & ~32'd1;
                    end
                    OPC_BRANCH:
                        if (take)
                            npc = pc_reg + immb;
                    OPC_LOAD:
                    begin
                        kind = ACC_LOAD; addr = a + immi;
                        nb = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
                        lp_next = 1'b1; ld_next = rd; lk_next = f3;
                    end
                    OPC_STORE:
                    begin
                        kind = ACC_STORE; addr = a + imms; sdata = b;
                        nb = (f3 == 3'd0) ? 3'd1 : ((f3 == 3'd1) ? 3'd2 : 3'd4);
                    end
                    OPC_ZERO:
                        if (w == 32'd0)
                        begin
                            cv = 1'b1; cc = rf_reg[11][7:0];
                        end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            lp_reg <= 1'b0;
            ld_reg <= '0;
            lk_reg <= '0;
            ov_reg <= 1'b0;
            for (int i = 1; i < 32; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            // hold the result until taken, refill on a new issue
            if (fire)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (fire)
            begin
                pc_reg <= npc;
                lp_reg <= lp_next;
                ld_reg <= ld_next;
                lk_reg <= lk_next;
                if (q_item.is_ret)
                begin
                    if (we && ld_reg != 5'd0)
                        rf_reg[ld_reg] <= ext;
                end
                else if (we && rd != 5'd0)
                begin
                    case (opc) inside
                        OPC_LUI:   rf_reg[rd] <= {w[31:12], 12'd0};
                        OPC_AUIPC: rf_reg[rd] <= {w[31:12], 12'd0} + pc_reg;
                        OPC_JAL, OPC_JALR: rf_reg[rd] <= pc4;
                        default:   rf_reg[rd] <= r;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            next_pc       <= npc;
            access_kind   <= kind;
            access_addr   <= addr;
            access_bytes  <= nb;
            store_data    <= sdata;
            illegal       <= q_item.illegal;
            console_valid <= cv;
            console_char  <= cc;
        end
    end

    assign out_valid = ov_reg;

endmodule

[design/rv32i_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top
// RV32I execute unit: decoupled classify front and execute back.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word: an instruction fetched
// at the current pc (op = 0) or the data for a pending load (op = 1).
// Output channel (out_valid/out_ready) returns one result word per input:
// next pc, any load/store request, illegal flag and console byte.
// An accepted word is written into the queue, then executed into the output
// register, where out_valid rises and the result waits until taken. The
// execute stage reads and writes the register file for one word per cycle
// while the receiver does not stall (out_ready high or no result waiting).
// The two-entry queue lets input be taken while a result waits; when the
// receiver stalls, the output register holds and the queue fills, then
// in_ready drops. Reset clears x1..x31, the pc and the pending-load state
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rv32i_execute_unit_top #(
    parameter int QDEPTH = rvx_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] instr,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic [1:0]  access_kind,
    output logic [31:0] access_addr,
    output logic [2:0]  access_bytes,
    output logic [31:0] store_data,
    output logic        illegal,
    output logic        console_valid,
    output logic [7:0]  console_char
);
    import rvx_pkg::*;

`include "rv32i_execute_unit_top_assert.svh"

    logic       q_valid, q_ready;
    rvx_item_t  q_item;

    rvx_front #(.DEPTH(QDEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .instr(instr), .load_data(load_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    rvx_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .access_kind(access_kind), .access_addr(access_addr),
        .access_bytes(access_bytes), .store_data(store_data), .illegal(illegal),
        .console_valid(console_valid), .console_char(console_char)
    );

    `RVX_ASSERT_IMP(a_ill_no_access, out_valid && illegal, access_kind == ACC_NONE, "illegal with access")
    `RVX_ASSERT_NEXT(a_issue_valid, q_valid && q_ready, out_valid, "result lost")
    `RVX_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !q_ready, "back advanced under stall")

endmodule
